/* src/rsm_pkg.sv */
package rsm_pkg;

    localparam int SAMPLE_DEPTH = 4096;
    localparam int MIX_DEPTH    = 4096;
    localparam int SMP_AW       = $clog2(SAMPLE_DEPTH);
    localparam int MIX_AW       = $clog2(MIX_DEPTH);

    // hits per slot during a gap fill: up to 2^32 / MIX_DEPTH, plus one
    localparam int CNT_W        = 32 - MIX_AW + 1;
    localparam int MIX_PROD_W   = CNT_W + 1 + 9;

    localparam int KIND_W       = 3;
    localparam int ADDR_W       = 12;
    localparam int VAL_W        = 8;
    localparam int TIME_W       = 32;
    localparam int LEN_W        = 13;
    localparam int IN_RATE_W    = 32;
    localparam int OUT_RATE_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam int STEP_W       = 48;
    localparam int DIV_N_W      = 96;
    localparam int DIV_D_W      = 48;
    localparam int DIV_Q_W      = 64;
    localparam int DIV_CNT_W    = $clog2(DIV_N_W + 1);

    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RUN     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESTART = 3'd5;

    localparam logic REPLY_STATUS = 1'b0;
    localparam logic REPLY_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_RATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE = 1'b1;

    localparam logic [IN_RATE_W-1:0]  IN_RATE_RST  = 32'd1458473891;
    localparam logic [OUT_RATE_W-1:0] OUT_RATE_RST = 16'd22050;
    localparam logic [VAL_W-1:0]      SILENCE      = 8'h80;

    typedef struct packed {
        logic latch;
        logic smp_we;
        logic mix_wr;
        logic mix_rd;
        logic flush;
        logic restart;
        logic div_step;
        logic step_save;
        logic gap_a;
        logic gap_b;
        logic gap_rd;
        logic gap_wr;
        logic gap_end;
        logic delta;
        logic mul_step;
        logic loop_rd;
        logic loop_wr;
        logic fin;
        logic div_fx1;
        logic q1_save;
        logic div_fx2;
        logic start_upd;
        logic held_rd;
        logic held_wr;
        logic clr_step;
        logic reply_load;
        logic reply_read;
    } rsm_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              gap;
        logic              gap_more;
        logic              mul_last;
        logic              loop_more;
        logic              fin_done;
        logic              div_done;
        logic              clr_done;
        logic              out_free;
    } rsm_stat_t;

endpackage

/* src/rsm_item_if.sv */
interface rsm_item_if
    import rsm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   address;
    logic [VAL_W-1:0]    sample_value;
    logic [TIME_W-1:0]   until_time;
    logic [LEN_W-1:0]    in_length;

    modport source (output valid, kind, address, sample_value, until_time, in_length,
                    input ready);
    modport sink   (input valid, kind, address, sample_value, until_time, in_length,
                    output ready);
endinterface

/* src/rsm_reply_if.sv */
interface rsm_reply_if
    import rsm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                reply_kind;
    logic [VAL_W-1:0]    read_value;
    logic                buffer_done;
    logic [TIME_W-1:0]   time_now;

    modport source (output valid, reply_kind, read_value, buffer_done, time_now,
                    input ready);
    modport sink   (input valid, reply_kind, read_value, buffer_done, time_now,
                    output ready);
endinterface

/* src/rsm_cfg_if.sv */
interface rsm_cfg_if
    import rsm_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/rsm_div.sv */
module rsm_div
    import rsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_Q_W-1:0] quotient
);
    logic [DIV_N_W-1:0]   num_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;
    logic                 ge;
    logic [DIV_D_W-1:0]   rem_next;

    // restoring divide, one quotient bit per cycle; only the low bits are kept
    assign shifted  = {rem_reg, num_reg[DIV_N_W-1]};
    assign ge       = shifted >= {1'b0, dvs_reg};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_N_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* src/rsm_dpath.sv */
module rsm_dpath
    import rsm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rsm_cmd_t                cmd,
    output rsm_stat_t               stat,
    input  logic [KIND_W-1:0]       kind,
    input  logic [ADDR_W-1:0]       address,
    input  logic [VAL_W-1:0]        sample_value,
    input  logic [TIME_W-1:0]       until_time,
    input  logic [LEN_W-1:0]        in_length,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    reply_ready,
    output logic                    reply_valid,
    output logic                    reply_kind,
    output logic [VAL_W-1:0]        read_value,
    output logic                    buffer_done,
    output logic [TIME_W-1:0]       time_now
);
    logic [IN_RATE_W-1:0]  in_rate_reg;
    logic [OUT_RATE_W-1:0] out_rate_reg;
    logic [31:0]           ct_reg;
    logic [63:0]           start_reg;
    logic [VAL_W-1:0]      held_reg;
    logic [MIX_AW:0]       clr_cnt_reg;
    logic                  out_valid_reg;
    logic [MIX_AW:0]       k_reg;
    logic [2:0]            mul_cnt_reg;

    logic [KIND_W-1:0]     kind_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [VAL_W-1:0]      val_reg;
    logic [TIME_W-1:0]     until_reg;
    logic [SMP_AW-1:0]     last_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  gap_reg;
    logic [63:0]           d_reg;
    logic [31:0]           n_reg;
    logic [63:0]           delta_reg;
    logic [63:0]           prod_reg;
    logic [63:0]           in_t_reg;
    logic                  done_reg;
    logic [63:0]           q1_reg;
    logic                  reply_kind_reg;
    logic [VAL_W-1:0]      read_value_reg;
    logic                  buffer_done_reg;
    logic [TIME_W-1:0]     time_now_reg;
    logic [VAL_W-1:0]      mix_q_reg;
    logic [VAL_W-1:0]      smp_q_reg;

    logic [VAL_W-1:0]      mix_mem [MIX_DEPTH];
    logic [VAL_W-1:0]      smp_mem [SAMPLE_DEPTH];

    logic [63:0]           p;
    logic [31:0]           len32;
    logic [SMP_AW-1:0]     last_in;
    logic [32:0]           n_raw;
    logic [32:0]           room;
    logic [31:0]           n_next;
    logic [31:0]           gap_lim;
    logic [MIX_AW-1:0]     gap_addr;
    logic [CNT_W-1:0]      c_gap;
    logic [CNT_W-1:0]      c_sel;
    logic [VAL_W-1:0]      smp_sel;
    logic signed [8:0]     smp_off;
    logic signed [MIX_PROD_W-1:0] prod_mix;
    logic signed [MIX_PROD_W:0]   r_mix;
    logic [VAL_W-1:0]      mixed;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           term;
    logic                  in_lt_last;
    logic [IN_RATE_W-1:0]  in_rate_eff;
    logic [OUT_RATE_W-1:0] out_rate_eff;
    logic                  div_start;
    logic [DIV_N_W-1:0]    div_num;
    logic [DIV_D_W-1:0]    div_dvs;
    logic                  div_done;
    logic [DIV_Q_W-1:0]    div_quo;
    logic [MIX_AW-1:0]     mix_item_idx;
    logic [SMP_AW-1:0]     smp_item_idx;
    logic                  mix_we;
    logic [MIX_AW-1:0]     mix_wa;
    logic [VAL_W-1:0]      mix_wd;
    logic                  mix_re;
    logic [MIX_AW-1:0]     mix_ra;
    logic                  smp_re;
    logic [SMP_AW-1:0]     smp_ra;
    logic [31:0]           addr32;

    assign p = {ct_reg, 32'd0};

    // buffer length clamped to 1..SAMPLE_DEPTH, kept as the last index
    always_comb
    begin
        len32 = 32'(in_length);
        if (len32 == 32'd0)
            len32 = 32'd1;
        if (len32 > 32'(SAMPLE_DEPTH))
            len32 = 32'(SAMPLE_DEPTH);
        last_in = SMP_AW'(len32 - 32'd1);
    end

    assign addr32       = 32'(addr_reg);
    assign mix_item_idx = addr32[MIX_AW-1:0];
    assign smp_item_idx = addr32[SMP_AW-1:0];

    // gap length in slots, rounded up and limited to the time range left
    assign n_raw  = {1'b0, d_reg[63:32]} + 33'(|d_reg[31:0]);
    assign room   = {1'b0, ~ct_reg};
    assign n_next = (n_raw > room) ? room[31:0] : n_raw[31:0];

    assign gap_lim  = (n_reg >= 32'(MIX_DEPTH)) ? 32'(MIX_DEPTH) : n_reg;
    assign gap_addr = ct_reg[MIX_AW-1:0] + k_reg[MIX_AW-1:0];
    assign c_gap    = CNT_W'(n_reg[31:MIX_AW])
                    + CNT_W'(k_reg[MIX_AW-1:0] < n_reg[MIX_AW-1:0]);

    // saturating mix of c copies of one sample into a slot
    always_comb
    begin
        c_sel    = cmd.gap_wr ? c_gap : CNT_W'(1);
        smp_sel  = cmd.gap_wr ? held_reg : smp_q_reg;
        smp_off  = $signed({1'b0, smp_sel}) - 9'sd128;
        prod_mix = $signed({1'b0, c_sel}) * smp_off;
        r_mix    = {prod_mix[MIX_PROD_W-1], prod_mix}
                 + $signed({{(MIX_PROD_W + 1 - VAL_W){1'b0}}, mix_q_reg});
        if (r_mix < 0)
            mixed = 8'h00;
        else if (r_mix > $signed((MIX_PROD_W + 1)'(255)))
            mixed = 8'hFF;
        else
            mixed = r_mix[VAL_W-1:0];
    end

    // fixed-point multiply: four partial products through one multiplier
    assign mul_a = mul_cnt_reg[1] ? delta_reg[63:32] : delta_reg[31:0];
    assign mul_b = mul_cnt_reg[0] ? 32'(step_reg[STEP_W-1:32]) : step_reg[31:0];

    always_comb
    begin
        case (mul_cnt_reg)
            3'd1:    term = {32'd0, prod_reg[63:32]};
            3'd2:    term = prod_reg;
            3'd3:    term = prod_reg;
            3'd4:    term = {prod_reg[31:0], 32'd0};
            default: term = 64'd0;
        endcase
    end

    assign in_lt_last = in_t_reg[63:32] < 32'(last_reg);

    assign in_rate_eff  = (in_rate_reg == '0) ? IN_RATE_W'(1) : in_rate_reg;
    assign out_rate_eff = (out_rate_reg == '0) ? OUT_RATE_W'(1) : out_rate_reg;

    assign div_start = cmd.div_step | cmd.div_fx1 | cmd.div_fx2;

    always_comb
    begin
        if (cmd.div_step)
        begin
            div_num = {48'd0, in_rate_eff, 16'd0};
            div_dvs = {32'd0, out_rate_eff};
        end
        else if (cmd.div_fx1)
        begin
            div_num = {32'(last_reg) + 32'd1, 64'd0};
            div_dvs = step_reg;
        end
        else
        begin
            div_num = {in_t_reg, 32'd0};
            div_dvs = step_reg;
        end
    end

    rsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // mix ring ports
    always_comb
    begin
        mix_we = cmd.clr_step | cmd.mix_wr | cmd.gap_wr | cmd.loop_wr;
        if (cmd.clr_step)
        begin
            mix_wa = clr_cnt_reg[MIX_AW-1:0];
            mix_wd = SILENCE;
        end
        else if (cmd.mix_wr)
        begin
            mix_wa = mix_item_idx;
            mix_wd = val_reg;
        end
        else if (cmd.gap_wr)
        begin
            mix_wa = gap_addr;
            mix_wd = mixed;
        end
        else
        begin
            mix_wa = ct_reg[MIX_AW-1:0];
            mix_wd = mixed;
        end
        mix_re = cmd.mix_rd | cmd.gap_rd | cmd.loop_rd;
        if (cmd.mix_rd)
            mix_ra = mix_item_idx;
        else if (cmd.gap_rd)
            mix_ra = gap_addr;
        else
            mix_ra = ct_reg[MIX_AW-1:0];
        smp_re = cmd.loop_rd | cmd.held_rd;
        smp_ra = cmd.held_rd ? last_reg : in_t_reg[32 +: SMP_AW];
    end

    always_ff @(posedge clk)
    begin
        if (mix_we)
            mix_mem[mix_wa] <= mix_wd;
        if (mix_re)
            mix_q_reg <= mix_mem[mix_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.smp_we)
            smp_mem[smp_item_idx] <= val_reg;
        if (smp_re)
            smp_q_reg <= smp_mem[smp_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rate_reg   <= IN_RATE_RST;
            out_rate_reg  <= OUT_RATE_RST;
            ct_reg        <= '0;
            start_reg     <= '0;
            held_reg      <= SILENCE;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            mul_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_IN_RATE)
                    in_rate_reg <= cfg_data;
                else if (cfg_index == CFG_OUT_RATE)
                    out_rate_reg <= cfg_data[OUT_RATE_W-1:0];
            end
            if (cmd.flush)
            begin
                ct_reg    <= '0;
                start_reg <= '0;
            end
            if (cmd.restart)
                start_reg <= p;
            if (cmd.gap_end)
                ct_reg <= ct_reg + n_reg;
            if (cmd.loop_wr)
                ct_reg <= ct_reg + 32'd1;
            if (cmd.start_upd)
                start_reg <= p + q1_reg - div_quo;
            if (cmd.held_wr)
                held_reg <= smp_q_reg;
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.gap_b)
                k_reg <= '0;
            if (cmd.gap_wr)
                k_reg <= k_reg + 1'b1;
            if (cmd.delta)
                mul_cnt_reg <= '0;
            if (cmd.mul_step)
                mul_cnt_reg <= mul_cnt_reg + 3'd1;
            if (cmd.reply_load)
                out_valid_reg <= 1'b1;
            else if (reply_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg  <= kind;
            addr_reg  <= address;
            val_reg   <= sample_value;
            until_reg <= until_time;
            last_reg  <= last_in;
        end
        if (cmd.step_save)
            step_reg <= div_quo[STEP_W-1:0];
        if (cmd.gap_a)
        begin
            gap_reg <= p < start_reg;
            d_reg   <= start_reg - p;
        end
        if (cmd.gap_b)
            n_reg <= n_next;
        if (cmd.delta)
        begin
            delta_reg <= (p >= start_reg) ? (p - start_reg) : 64'd0;
            in_t_reg  <= '0;
        end
        if (cmd.mul_step)
        begin
            if (mul_cnt_reg < 3'd4)
                prod_reg <= mul_a * mul_b;
            in_t_reg <= in_t_reg + term;
        end
        if (cmd.loop_wr)
            in_t_reg <= in_t_reg + 64'(step_reg);
        if (cmd.fin)
            done_reg <= ~in_lt_last;
        if (cmd.q1_save)
            q1_reg <= div_quo;
        if (cmd.reply_load)
        begin
            if (cmd.reply_read)
            begin
                reply_kind_reg  <= REPLY_READ;
                read_value_reg  <= mix_q_reg;
                buffer_done_reg <= 1'b0;
                time_now_reg    <= '0;
            end
            else
            begin
                reply_kind_reg  <= REPLY_STATUS;
                read_value_reg  <= '0;
                buffer_done_reg <= done_reg;
                time_now_reg    <= ct_reg;
            end
        end
    end

    always_comb
    begin
        stat.kind      = kind_reg;
        stat.gap       = gap_reg;
        stat.gap_more  = 32'(k_reg) < gap_lim;
        stat.mul_last  = mul_cnt_reg == 3'd4;
        stat.loop_more = (ct_reg < until_reg) && in_lt_last;
        stat.fin_done  = ~in_lt_last;
        stat.div_done  = div_done;
        stat.clr_done  = clr_cnt_reg == (MIX_AW + 1)'(MIX_DEPTH);
        stat.out_free  = ~out_valid_reg | reply_ready;
    end

    assign reply_valid = out_valid_reg;
    assign reply_kind  = reply_kind_reg;
    assign read_value  = read_value_reg;
    assign buffer_done = buffer_done_reg;
    assign time_now    = time_now_reg;
endmodule

/* src/rsm_ctrl.sv */
module rsm_ctrl
    import rsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  rsm_stat_t stat,
    output rsm_cmd_t  cmd
);
    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISP     = 5'd2;
    localparam logic [4:0] S_RD_REPLY = 5'd3;
    localparam logic [4:0] S_STEP     = 5'd4;
    localparam logic [4:0] S_GAP_A    = 5'd5;
    localparam logic [4:0] S_GAP_B    = 5'd6;
    localparam logic [4:0] S_GAP_CHK  = 5'd7;
    localparam logic [4:0] S_GAP_RD   = 5'd8;
    localparam logic [4:0] S_GAP_WR   = 5'd9;
    localparam logic [4:0] S_GAP_END  = 5'd10;
    localparam logic [4:0] S_DELTA    = 5'd11;
    localparam logic [4:0] S_MUL      = 5'd12;
    localparam logic [4:0] S_LOOP_CHK = 5'd13;
    localparam logic [4:0] S_LOOP_RD  = 5'd14;
    localparam logic [4:0] S_LOOP_WR  = 5'd15;
    localparam logic [4:0] S_FIN      = 5'd16;
    localparam logic [4:0] S_DIV1     = 5'd17;
    localparam logic [4:0] S_DIV2     = 5'd18;
    localparam logic [4:0] S_HELD_RD  = 5'd19;
    localparam logic [4:0] S_HELD_WR  = 5'd20;
    localparam logic [4:0] S_RUN_REPLY = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (stat.clr_done)
                    state_next = S_IDLE;
                else
                    cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_IDLE;
                case (stat.kind)
                    KIND_LOAD:    cmd.smp_we = 1'b1;
                    KIND_WRITE:   cmd.mix_wr = 1'b1;
                    KIND_FLUSH:   cmd.flush = 1'b1;
                    KIND_RESTART: cmd.restart = 1'b1;
                    KIND_READ:
                    begin
                        cmd.mix_rd = 1'b1;
                        state_next = S_RD_REPLY;
                    end
                    KIND_RUN:
                    begin
                        cmd.div_step = 1'b1;
                        state_next   = S_STEP;
                    end
                    default:      state_next = S_IDLE;
                endcase
            end
            S_RD_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.reply_load = 1'b1;
                    cmd.reply_read = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_STEP:
            begin
                if (stat.div_done)
                begin
                    cmd.step_save = 1'b1;
                    state_next    = S_GAP_A;
                end
            end
            S_GAP_A:
            begin
                cmd.gap_a  = 1'b1;
                state_next = S_GAP_B;
            end
            S_GAP_B:
            begin
                if (stat.gap)
                begin
                    cmd.gap_b  = 1'b1;
                    state_next = S_GAP_CHK;
                end
                else
                    state_next = S_DELTA;
            end
            S_GAP_CHK:  state_next = stat.gap_more ? S_GAP_RD : S_GAP_END;
            S_GAP_RD:
            begin
                cmd.gap_rd = 1'b1;
                state_next = S_GAP_WR;
            end
            S_GAP_WR:
            begin
                cmd.gap_wr = 1'b1;
                state_next = S_GAP_CHK;
            end
            S_GAP_END:
            begin
                cmd.gap_end = 1'b1;
                state_next  = S_DELTA;
            end
            S_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                    state_next = S_LOOP_CHK;
            end
            S_LOOP_CHK: state_next = stat.loop_more ? S_LOOP_RD : S_FIN;
            S_LOOP_RD:
            begin
                cmd.loop_rd = 1'b1;
                state_next  = S_LOOP_WR;
            end
            S_LOOP_WR:
            begin
                cmd.loop_wr = 1'b1;
                state_next  = S_LOOP_CHK;
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                if (stat.fin_done)
                begin
                    cmd.div_fx1 = 1'b1;
                    state_next  = S_DIV1;
                end
                else
                    state_next = S_RUN_REPLY;
            end
            S_DIV1:
            begin
                if (stat.div_done)
                begin
                    cmd.q1_save = 1'b1;
                    cmd.div_fx2 = 1'b1;
                    state_next  = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (stat.div_done)
                begin
                    cmd.start_upd = 1'b1;
                    state_next    = S_HELD_RD;
                end
            end
            S_HELD_RD:
            begin
                cmd.held_rd = 1'b1;
                state_next  = S_HELD_WR;
            end
            S_HELD_WR:
            begin
                cmd.held_wr = 1'b1;
                state_next  = S_RUN_REPLY;
            end
            S_RUN_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.reply_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end
endmodule

/* src/resampling_saturating_mixer_core.sv */
// Channel  Dir  Payload                                          Transfer
// item     in   kind, address, sample_value, until_time, in_length valid & ready
// reply    out  reply_kind, read_value, buffer_done, time_now      valid & ready
// cfg      in   index, data (index 0 in_rate, 1 out_rate)          valid & ready
//
// Load, write, flush and restart finish in the dispatch state; a slot read then
// waits to load its reply. A run waits on the step divide, sweeps each gap slot
// (at most MIX_DEPTH), mixes each output slot in turn and, at the end of the
// buffer, runs two more divides; the bit-serial divider and the single-ported
// sample store set its pace.
// After reset a clearing pass fills the mix ring with silence; no item is taken
// meanwhile. One item is worked at a time; a waiting reply holds the block only
// when the next reply is ready to be loaded.
module resampling_saturating_mixer_core
    import rsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rsm_item_if.sink    item,
    rsm_reply_if.source reply,
    rsm_cfg_if.sink     cfg
);
    rsm_cmd_t  cmd;
    rsm_stat_t stat;

    assign cfg.ready = 1'b1;

    rsm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    rsm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (item.kind),
        .address      (item.address),
        .sample_value (item.sample_value),
        .until_time   (item.until_time),
        .in_length    (item.in_length),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .reply_ready  (reply.ready),
        .reply_valid  (reply.valid),
        .reply_kind   (reply.reply_kind),
        .read_value   (reply.read_value),
        .buffer_done  (reply.buffer_done),
        .time_now     (reply.time_now)
    );
endmodule

/* sim/resampling_saturating_mixer_core_tb.sv */
`timescale 1ns / 100ps

module resampling_saturating_mixer_core_tb;
    import rsm_pkg::*;

    localparam int IDLE_LIMIT  = 60000;
    localparam int SETTLE_CYC  = 500;
    // runs never use more samples than this, so only these entries are loaded
    localparam int SMP_LOADED  = 256;

    typedef struct packed {
        logic              reply_kind;
        logic [VAL_W-1:0]  read_value;
        logic              buffer_done;
        logic [TIME_W-1:0] time_now;
    } mix_reply_t;

    logic clk;
    logic rst_n;

    rsm_item_if  item_ch();
    rsm_reply_if reply_ch();
    rsm_cfg_if   cfg_ch();

    resampling_saturating_mixer_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .reply (reply_ch),
        .cfg   (cfg_ch)
    );

    // predicted block state
    logic [VAL_W-1:0]      smp_mem [SAMPLE_DEPTH];
    logic [VAL_W-1:0]      ring    [MIX_DEPTH];
    bit   [31:0]           ch_time;
    bit   [63:0]           start_at;
    bit   [7:0]            held;
    bit   [IN_RATE_W-1:0]  rate_in;
    bit   [OUT_RATE_W-1:0] rate_out;

    mix_reply_t pending_replies[$];
    int         errors;
    int         burst_left;
    int         idle_cycles;
    int         stall_left;
    int         stall_mode;
    int         cyc_cnt;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit [7:0] mix_sat(bit [7:0] slot, bit [7:0] smp, bit [63:0] count);
        longint r;
        r = longint'({56'b0, slot}) + longint'(count) * (longint'({56'b0, smp}) - 128);
        if (r < 0)
            return 8'h00;
        if (r > 255)
            return 8'hFF;
        return r[7:0];
    endfunction

    function automatic bit [63:0] fix_div(bit [63:0] x, bit [63:0] y);
        bit [127:0] q;
        q = {32'b0, x, 32'b0} / {64'b0, y};
        return q[63:0];
    endfunction

    function automatic bit [63:0] fix_mul(bit [63:0] x, bit [63:0] y);
        bit [127:0] p;
        p = {64'b0, x} * {64'b0, y};
        return p[95:32];
    endfunction

    function automatic bit [63:0] slot_hits(bit [63:0] h, int s);
        return h / MIX_DEPTH + ((s < (h % MIX_DEPTH)) ? 64'd1 : 64'd0);
    endfunction

    // output time reached once the held-sample fill is done
    function automatic bit [63:0] gap_end_time();
        bit [63:0] p, d, n, room;
        p = {ch_time, 32'b0};
        if (p >= start_at)
            return {32'b0, ch_time};
        d = start_at - p;
        n = (d >> 32) + ((d[31:0] != 0) ? 64'd1 : 64'd0);
        room = 64'hFFFF_FFFF - {32'b0, ch_time};
        if (n > room)
            n = room;
        return {32'b0, ch_time} + n;
    endfunction

    function automatic void fill_gap();
        bit [63:0] lo, hi, c;
        lo = {32'b0, ch_time};
        hi = gap_end_time();
        if (hi == lo)
            return;
        for (int s = 0; s < MIX_DEPTH; s++)
        begin
            c = slot_hits(hi, s) - slot_hits(lo, s);
            if (c != 0)
                ring[s] = mix_sat(ring[s], held, c);
        end
        ch_time = hi[31:0];
    endfunction

    function automatic bit resample_run(bit [31:0] stop_at, bit [LEN_W-1:0] len_in);
        bit [63:0] ir, orate, step, p, delta, in_t, last;
        bit [31:0] out_t;
        bit [LEN_W-1:0] len;
        ir    = (rate_in == 0) ? 64'd1 : {32'b0, rate_in};
        orate = (rate_out == 0) ? 64'd1 : {48'b0, rate_out};
        step  = (ir << 16) / orate;
        len   = len_in;
        if (len == 0)
            len = LEN_W'(1);
        if (len > SAMPLE_DEPTH)
            len = LEN_W'(SAMPLE_DEPTH);
        last = {51'b0, len} - 64'd1;
        fill_gap();
        p = {ch_time, 32'b0};
        delta = (p >= start_at) ? p - start_at : 64'd0;
        in_t = fix_mul(delta, step);
        out_t = ch_time;
        while (out_t < stop_at && (in_t >> 32) < last)
        begin
            ring[out_t[MIX_AW-1:0]] = mix_sat(ring[out_t[MIX_AW-1:0]],
                                              smp_mem[in_t[43:32]], 64'd1);
            in_t += step;
            out_t++;
        end
        ch_time = out_t;
        if ((in_t >> 32) < last)
            return 1'b0;
        start_at = {out_t, 32'b0} + fix_div({19'b0, len, 32'b0}, step) - fix_div(in_t, step);
        held = smp_mem[last[11:0]];
        return 1'b1;
    endfunction

    function automatic void predict_item(bit [2:0] kind, bit [11:0] addr, bit [7:0] val,
                                         bit [31:0] stop_at, bit [LEN_W-1:0] len);
        mix_reply_t r;
        case (kind)
            KIND_LOAD:    smp_mem[addr] = val;
            KIND_WRITE:   ring[addr] = val;
            KIND_FLUSH:
            begin
                ch_time = 0;
                start_at = 0;
            end
            KIND_RESTART: start_at = {ch_time, 32'b0};
            KIND_RUN:
            begin
                r.reply_kind  = REPLY_STATUS;
                r.read_value  = '0;
                r.buffer_done = resample_run(stop_at, len);
                r.time_now    = ch_time;
                pending_replies.push_back(r);
            end
            KIND_READ:
            begin
                r.reply_kind  = REPLY_READ;
                r.read_value  = ring[addr];
                r.buffer_done = 1'b0;
                r.time_now    = '0;
                pending_replies.push_back(r);
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(bit [2:0] kind, bit [31:0] addr, bit [31:0] val,
                             bit [31:0] stop_at, bit [31:0] len);
        if (burst_left <= 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= kind;
        item_ch.address      <= addr[ADDR_W-1:0];
        item_ch.sample_value <= val[VAL_W-1:0];
        item_ch.until_time   <= stop_at;
        item_ch.in_length    <= len[LEN_W-1:0];
        do
            @(posedge clk);
        while (!item_ch.ready);
        burst_left--;
        predict_item(kind, addr[ADDR_W-1:0], val[VAL_W-1:0], stop_at, len[LEN_W-1:0]);
    endtask

    task automatic wait_drain();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_IN_RATE)
            rate_in = data;
        else
            rate_out = data[15:0];
    endtask

    task automatic set_rates(bit [31:0] in_r, bit [15:0] out_r);
        wait_drain();
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_write(CFG_IN_RATE, in_r);
        cfg_write(CFG_OUT_RATE, {16'b0, out_r});
    endtask

    // until_time a little past the end of the held-sample fill
    function automatic bit [31:0] near_until(bit [31:0] span);
        bit [63:0] u;
        u = gap_end_time() + {32'b0, span};
        return (u > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : u[31:0];
    endfunction

    task automatic load_samples();
        for (int i = 0; i < SMP_LOADED; i++)
            send_item(KIND_LOAD, 32'(i), $urandom, $urandom, $urandom);
    endtask

    task automatic test_slot_access();
        send_item(KIND_READ, 32'd0, $urandom, $urandom, $urandom);
        send_item(KIND_READ, 32'hFFF, $urandom, $urandom, $urandom);
        send_item(KIND_WRITE, 32'hFFF, 32'hFF, $urandom, $urandom);
        send_item(KIND_WRITE, 32'd0, 32'h00, $urandom, $urandom);
        send_item(KIND_READ, 32'hFFF, $urandom, $urandom, $urandom);
        send_item(KIND_READ, 32'd0, $urandom, $urandom, $urandom);
        send_item(3'd6, $urandom, $urandom, $urandom, $urandom);
        send_item(3'd7, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_runs_and_lengths();
        send_item(KIND_LOAD, 32'd1, 32'hFF, $urandom, $urandom);
        send_item(KIND_LOAD, 32'd2, 32'h00, $urandom, $urandom);
        send_item(KIND_RUN, $urandom, $urandom, 32'd0, 32'd5);
        send_item(KIND_RUN, $urandom, $urandom, near_until(40), 32'd0);
        send_item(KIND_RUN, $urandom, $urandom, near_until(30), 32'd4);
        // from a fresh start, the long buffers below stop at until_time early on
        send_item(KIND_RESTART, $urandom, $urandom, $urandom, $urandom);
        send_item(KIND_RUN, $urandom, $urandom, near_until(60), 32'd8191);
        send_item(KIND_RUN, $urandom, $urandom, near_until(20), 32'd4096);
        send_item(KIND_READ, 32'd0, $urandom, $urandom, $urandom);
        send_item(KIND_FLUSH, $urandom, $urandom, $urandom, $urandom);
        send_item(KIND_RUN, $urandom, $urandom, near_until(10), 32'd2);
    endtask

    task automatic test_rate_extremes();
        // step so large that one output slot covers the whole buffer
        set_rates(32'hFFFF_FFFF, 16'd1);
        send_item(KIND_RUN, $urandom, $urandom, 32'hFFFF_FFFF, 32'(SMP_LOADED));
        send_item(KIND_RUN, $urandom, $urandom, 32'hFFFF_FFFF, 32'd1);
        set_rates(32'd0, 16'd0);
        send_item(KIND_RESTART, $urandom, $urandom, $urandom, $urandom);
        send_item(KIND_RUN, $urandom, $urandom, near_until(50), 32'd3);
        set_rates(32'd1, 16'd65535);
        send_item(KIND_RUN, $urandom, $urandom, near_until(100), 32'd2);
    endtask

    task automatic test_time_range_end();
        // step of two: a one-sample buffer pushes the start time 2^31 slots ahead
        set_rates(32'd1, 16'd32768);
        send_item(KIND_FLUSH, $urandom, $urandom, $urandom, $urandom);
        repeat (5)
            send_item(KIND_RUN, $urandom, $urandom, $urandom, 32'd1);
        send_item(KIND_RUN, $urandom, $urandom, near_until(40), 32'd3);
        send_item(KIND_READ, 32'hFFF, $urandom, $urandom, $urandom);
        send_item(KIND_FLUSH, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic random_phase(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_item(KIND_LOAD, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 55)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(KIND_RESTART, $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 9) == 0)
                    send_item(KIND_RUN, $urandom, $urandom,
                              $urandom_range(0, 32'(gap_end_time())),
                              $urandom_range(0, SMP_LOADED));
                else
                    send_item(KIND_RUN, $urandom, $urandom,
                              near_until($urandom_range(0, 160)),
                              ($urandom_range(0, 7) == 0) ? $urandom_range(1, SMP_LOADED)
                                                          : $urandom_range(1, 64));
            end
            else if (pick < 65)
                send_item(KIND_WRITE, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 88)
                send_item(KIND_READ, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 93)
                send_item(KIND_FLUSH, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 98)
                send_item(KIND_RESTART, $urandom, $urandom, $urandom, $urandom);
            else
                send_item(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 99) == 0)
                wait_drain();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (reply_ch.valid && reply_ch.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply kind=%0b value=%02h done=%0b time=%08h",
                         $time, reply_ch.reply_kind, reply_ch.read_value,
                         reply_ch.buffer_done, reply_ch.time_now);
            end
            else
            begin
                mix_reply_t e;
                e = pending_replies.pop_front();
                if (reply_ch.reply_kind !== e.reply_kind)
                begin
                    errors++;
                    $display("%0t: reply_kind expected %0b actual %0b",
                             $time, e.reply_kind, reply_ch.reply_kind);
                end
                if (reply_ch.read_value !== e.read_value)
                begin
                    errors++;
                    $display("%0t: read_value expected %02h actual %02h",
                             $time, e.read_value, reply_ch.read_value);
                end
                if (reply_ch.buffer_done !== e.buffer_done)
                begin
                    errors++;
                    $display("%0t: buffer_done expected %0b actual %0b",
                             $time, e.buffer_done, reply_ch.buffer_done);
                end
                if (reply_ch.time_now !== e.time_now)
                begin
                    errors++;
                    $display("%0t: time_now expected %08h actual %08h",
                             $time, e.time_now, reply_ch.time_now);
                end
            end
        end
    end

    // reply-side backpressure with a randomly changing stall pattern
    always @(posedge clk)
    begin
        bit rdy;
        cyc_cnt++;
        if (cyc_cnt % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        rdy = 1'b1;
        if (stall_left > 0)
        begin
            rdy = 1'b0;
            stall_left--;
        end
        else if (stall_mode == 1 && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 4);
        else if (stall_mode == 2 && $urandom_range(0, 15) == 0)
            stall_left = $urandom_range(5, 30);
        else if (stall_mode == 3)
            rdy = ($urandom_range(0, 1) != 0);
        reply_ch.ready <= rdy;
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (reply_ch.valid && reply_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        item_ch.valid        = 1'b0;
        item_ch.kind         = '0;
        item_ch.address      = '0;
        item_ch.sample_value = '0;
        item_ch.until_time   = '0;
        item_ch.in_length    = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        reply_ch.ready       = 1'b0;
        errors      = 0;
        burst_left  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        stall_mode  = 0;
        cyc_cnt     = 0;
        for (int i = 0; i < MIX_DEPTH; i++)
            ring[i] = SILENCE;
        for (int i = 0; i < SAMPLE_DEPTH; i++)
            smp_mem[i] = '0;
        ch_time  = 0;
        start_at = 0;
        held     = SILENCE;
        rate_in  = IN_RATE_RST;
        rate_out = OUT_RATE_RST;
        rst_n    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_slot_access();
        load_samples();
        test_runs_and_lengths();
        test_rate_extremes();
        test_time_range_end();

        set_rates(IN_RATE_RST, OUT_RATE_RST);
        random_phase(140);
        set_rates({16'($urandom_range(8000, 48000)), 16'($urandom)},
                  16'($urandom_range(8000, 48000)));
        random_phase(140);
        set_rates($urandom, 16'($urandom));
        random_phase(140);
        set_rates(32'hFFFF_FFFF, 16'hFFFF);
        random_phase(140);

        wait_drain();
        repeat (SETTLE_CYC) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
